### hdl/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Shared types, codes and microcode for the 4-bit character-LCD writer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

   localparam int STEP_W = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 3;

   // request kinds
   localparam logic [1:0] KIND_INIT = 2'd0;
   localparam logic [1:0] KIND_CHAR = 2'd1;
   localparam logic [1:0] KIND_POS  = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_OFF = 2'd1;
   localparam logic [1:0] ST_ROW = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 1'd1;

   // nibble sources of a control word
   localparam logic [1:0] SRC_CONST = 2'd0;
   localparam logic [1:0] SRC_HI    = 2'd1;
   localparam logic [1:0] SRC_LO    = 2'd2;

   // microcode entry points
   localparam logic [STEP_W-1:0] ENT_INIT = 5'd0;
   localparam logic [STEP_W-1:0] ENT_CHR  = 5'd16;
   localparam logic [STEP_W-1:0] ENT_CMD  = 5'd18;
   localparam logic [STEP_W-1:0] ENT_STAT = 5'd20;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CMD_SET_ADDR = 8'h80;
   localparam logic [5:0] COL_MAX      = 6'd40;
   localparam logic [2:0] ROW_LIMIT    = 3'd3;

   localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

   localparam logic [3:0] INIT_NIB [16] = '{
      4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8, 4'h0, 4'h8,
      4'h0, 4'h1, 4'h0, 4'h6, 4'h0, 4'hC, 4'h8, 4'h0};

   localparam logic [14:0] INIT_WAIT [16] = '{
      15'd20000, 15'd1000, 15'd0, 15'd0, 15'd40, 15'd0, 15'd40, 15'd0,
      15'd40, 15'd0, 15'd2000, 15'd0, 15'd2000, 15'd0, 15'd0, 15'd0};

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_code;
      logic [1:0] row;
      logic [5:0] column;
   } req_type;

   typedef struct packed {
      logic        bus_write;
      logic [3:0]  nibble;
      logic        register_select;
      logic [14:0] wait_before_us;
      logic [1:0]  status;
      logic [1:0]  cursor_row;
      logic [5:0]  cursor_column;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        wr;
      logic [1:0]  src;
      logic [3:0]  nib;
      logic        rs;
      logic [14:0] wait_us;
      logic        last;
   } ctl_word_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] entry;
   } dispatch_type;

   typedef struct packed {
      logic         busy;
      logic         fire;
      ctl_word_type ctl;
   } seq_out_type;

   function automatic ctl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      w = '{wr: 1'b0, src: SRC_CONST, nib: 4'h0, rs: 1'b0, wait_us: 15'd0, last: 1'b1};
      case (step) inside
         [ENT_INIT:ENT_INIT + 5'd15]: begin
            w.wr      = 1'b1;
            w.nib     = INIT_NIB[step[3:0]];
            w.wait_us = INIT_WAIT[step[3:0]];
            w.last    = (step[3:0] == 4'hF);
         end
         ENT_CHR: begin
            w.wr   = 1'b1;
            w.src  = SRC_HI;
            w.rs   = 1'b1;
            w.last = 1'b0;
         end
         ENT_CHR + 5'd1: begin
            w.wr  = 1'b1;
            w.src = SRC_LO;
            w.rs  = 1'b1;
         end
         ENT_CMD: begin
            w.wr   = 1'b1;
            w.src  = SRC_HI;
            w.last = 1'b0;
         end
         ENT_CMD + 5'd1: begin
            w.wr  = 1'b1;
            w.src = SRC_LO;
         end
         default: begin
            w.wr = 1'b0;
         end
      endcase
      return w;
   endfunction

endpackage

### hdl/lcdnw_sequencer.sv
// ----------------------------------------------------------------------------
// lcdnw_sequencer
// Step counter over the microcode ROM; one control word per result.
// ----------------------------------------------------------------------------
module lcdnw_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  lcdnw_pkg::dispatch_type dispatch,
   input  logic                   room,
   output lcdnw_pkg::seq_out_type  seq_out
);
   import lcdnw_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   ctl_word_type      ctl;
   logic              fire;

   assign ctl  = ucode_rom(step_ff);
   assign fire = busy_ff && room;

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (dispatch.start) begin
         step_in = dispatch.entry;
         busy_in = 1'b1;
      end else if (fire) begin
         if (ctl.last) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ENT_STAT;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   assign seq_out.busy = busy_ff;
   assign seq_out.fire = fire;
   assign seq_out.ctl  = ctl;

`ifndef SYNTH
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      dispatch.start |-> !busy_ff)
      else $error("dispatch while sequencer busy");
   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      fire && ctl.last |=> !busy_ff)
      else $error("sequencer stayed busy after last word");
`endif

endmodule

### hdl/lcdnw_datapath.sv
// ----------------------------------------------------------------------------
// lcdnw_datapath
// Request decode, cursor and operand registers, and the result register.
// ----------------------------------------------------------------------------
module lcdnw_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  lcdnw_pkg::req_type       req_data,
   input  logic                    display_enabled,
   input  logic [2:0]              rows_in_use,
   input  lcdnw_pkg::seq_out_type   seq_out,
   input  logic                    rsp_ready,
   output lcdnw_pkg::dispatch_type  dispatch,
   output logic                    room,
   output logic                    rsp_valid,
   output lcdnw_pkg::rsp_type       rsp_data
);
   import lcdnw_pkg::*;

   logic [1:0]  row_ff, row_in;
   logic [5:0]  col_ff, col_in;
   logic [7:0]  opnd_ff, opnd_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [2:0]  rows_eff;
   logic        newline;
   logic [2:0]  tgt_row;
   logic [5:0]  tgt_col;
   logic [5:0]  tgt_col_sat;
   logic [5:0]  col_next;
   logic        reject;
   logic [7:0]  cmd;
   logic [STEP_W-1:0] entry;
   logic [3:0]  nib_sel;

   always_comb begin
      rows_eff    = (rows_in_use == 3'd0) ? 3'd1 : rows_in_use;
      newline     = (req_data.kind == KIND_CHAR) && (req_data.char_code == CHAR_NEWLINE);
      tgt_row     = newline ? ({1'b0, row_ff} + 3'd1) : {1'b0, req_data.row};
      tgt_col     = newline ? 6'd0 : req_data.column;
      tgt_col_sat = (tgt_col > COL_MAX) ? COL_MAX : tgt_col;
      col_next    = (col_ff >= COL_MAX) ? COL_MAX : (col_ff + 6'd1);
      reject      = (tgt_row >= rows_eff) || (tgt_row > ROW_LIMIT);
      cmd         = CMD_SET_ADDR + ROW_BASE[tgt_row[1:0]] + {2'b00, tgt_col};

      entry     = ENT_STAT;
      status_in = ST_OK;
      opnd_in   = opnd_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (!display_enabled) begin
         status_in = ST_OFF;
      end else begin
         case (req_data.kind)
            KIND_INIT: begin
               entry  = ENT_INIT;
               row_in = 2'd0;
               col_in = 6'd0;
            end
            KIND_CHAR, KIND_POS: begin
               if (req_data.kind == KIND_CHAR && !newline) begin
                  entry   = ENT_CHR;
                  opnd_in = req_data.char_code;
                  col_in  = col_next;
               end else if (reject) begin
                  status_in = ST_ROW;
               end else begin
                  entry   = ENT_CMD;
                  opnd_in = cmd;
                  row_in  = tgt_row[1:0];
                  col_in  = tgt_col_sat;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   assign dispatch.start = start;
   assign dispatch.entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= 2'd0;
         col_ff <= 6'd0;
      end else if (start) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         opnd_ff   <= opnd_in;
         status_ff <= status_in;
      end
   end

   assign room = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (seq_out.ctl.src)
         SRC_HI:  nib_sel = opnd_ff[7:4];
         SRC_LO:  nib_sel = opnd_ff[3:0];
         default: nib_sel = seq_out.ctl.nib;
      endcase
      rsp_in.bus_write       = seq_out.ctl.wr;
      rsp_in.nibble          = nib_sel;
      rsp_in.register_select = seq_out.ctl.rs;
      rsp_in.wait_before_us  = seq_out.ctl.wait_us;
      rsp_in.status          = status_ff;
      rsp_in.cursor_row      = row_ff;
      rsp_in.cursor_column   = col_ff;
      rsp_in.last            = seq_out.ctl.last;

      rsp_valid_in = rsp_valid_ff;
      if (seq_out.fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_out.fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_MAX)
      else $error("cursor column beyond limit");
   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.bus_write |-> rsp_ff.last && rsp_ff.nibble == 4'h0)
      else $error("non-writing result is not a lone final result");
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.bus_write |-> rsp_ff.status == ST_OK)
      else $error("bus write carries an error status");
`endif

endmodule

### hdl/char_lcd_nibble_writer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_top
// Character-LCD 4-bit bus writer: requests in, nibble writes out.
// ----------------------------------------------------------------------------
// One request is taken at a time. After a transfer on req, the microcode
// sequencer emits one result per cycle into the output register while it
// has room (empty, or rsp_ready high): 16 for init, 2 for a character,
// newline or cursor position, 1 for a rejected, disabled or unused request.
// req_ready rises at the clock edge that loads the final result into the
// output register, so the next request can transfer while that result still
// waits. Each result carries the extra wait in microseconds to apply before
// strobing its nibble.
module char_lcd_nibble_writer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  lcdnw_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output lcdnw_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [lcdnw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lcdnw_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import lcdnw_pkg::*;

   logic         enable_ff;
   logic [2:0]   rows_ff;
   logic         start;
   dispatch_type dispatch;
   seq_out_type  seq_out;
   logic         room;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         rows_ff   <= 3'd2;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_ROWS:   rows_ff   <= csr_wdata;
            default:    rows_ff   <= rows_ff;
         endcase
      end
   end

   assign req_ready = !seq_out.busy;
   assign start     = req_valid && req_ready;

   lcdnw_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_data        (req_data),
      .display_enabled (enable_ff),
      .rows_in_use     (rows_ff),
      .seq_out         (seq_out),
      .rsp_ready       (rsp_ready),
      .dispatch        (dispatch),
      .room            (room),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data)
   );

   lcdnw_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .dispatch (dispatch),
      .room     (room),
      .seq_out  (seq_out)
   );

endmodule
